// ----- rtl/core/gpmm_pkg.sv -----
// gpmm_pkg: widths, pipeline beat types and the degree function shared by
// the GF(2) polynomial multiply/reduce pipeline. No dependencies.
`default_nettype none

package gpmm_pkg;

    localparam int POLY_WIDTH = 64;
    localparam int DEG_W      = $clog2(POLY_WIDTH);

    // carry-less multiply: operand b bits consumed per stage
    localparam int MUL_CHUNK  = 16;
    localparam int MUL_STAGES = (POLY_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;

    // reduction: product bits consumed per stage, MSB first
    localparam int RED_STEPS  = 8;
    localparam int RED_STAGES = (POLY_WIDTH + RED_STEPS - 1) / RED_STEPS;
    localparam int PAD_W      = RED_STAGES * RED_STEPS;

    typedef logic [POLY_WIDTH-1:0] poly_t;
    typedef logic [DEG_W-1:0]      deg_t;

    typedef struct packed {
        logic  valid;
        logic  ovf;
        poly_t a;
        poly_t b;
        poly_t acc;
    } mul_beat_t;

    // u holds the running remainder left-aligned so its top bit is the
    // reduction test bit
    typedef struct packed {
        logic             valid;
        logic             ovf;
        logic [PAD_W-1:0] p;
        poly_t            u;
    } red_beat_t;

    typedef struct packed {
        deg_t  shift;   // POLY_WIDTH-1 - deg(modulus)
        poly_t mn;      // modulus shifted so its top bit sits at POLY_WIDTH-1
        poly_t sel;     // one-hot insert position for the next product bit
    } mod_cfg_t;

    // index of highest set bit, zero for the zero polynomial
    function automatic deg_t poly_degree(input poly_t p);
        deg_t d;
        d = '0;
        for (int i = 1; i < POLY_WIDTH; i++) begin
            if (p[i]) begin
                d = deg_t'(i);
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gpmm_degree.sv -----
// gpmm_degree: entry stage; registers the operands and flags a degree sum
// above POLY_WIDTH-1. Depends on gpmm_pkg.
`default_nettype none

module gpmm_degree (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire gpmm_pkg::poly_t     a,
    input  wire gpmm_pkg::poly_t     b,
    output gpmm_pkg::mul_beat_t      beat_out
);

    gpmm_pkg::mul_beat_t              beat_reg;
    gpmm_pkg::mul_beat_t              beat_next;
    logic [gpmm_pkg::DEG_W:0]         deg_sum;

    always_comb
    begin
        deg_sum = {1'b0, gpmm_pkg::poly_degree(a)} + {1'b0, gpmm_pkg::poly_degree(b)};
        beat_next.valid = accept;
        beat_next.ovf   = deg_sum > (gpmm_pkg::DEG_W + 1)'(gpmm_pkg::POLY_WIDTH - 1);
        beat_next.a     = a;
        beat_next.b     = b;
        beat_next.acc   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            beat_reg.valid <= 1'b0;
        end else begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gpmm_clmul_stage.sv -----
// gpmm_clmul_stage: one register stage of the carry-less multiply; folds
// MUL_CHUNK bits of operand b into the accumulator. Depends on gpmm_pkg.
`default_nettype none

module gpmm_clmul_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gpmm_pkg::mul_beat_t beat_in,
    output gpmm_pkg::mul_beat_t      beat_out
);

    gpmm_pkg::mul_beat_t              beat_reg;
    gpmm_pkg::mul_beat_t              beat_next;
    gpmm_pkg::poly_t                  acc;
    logic [gpmm_pkg::MUL_CHUNK-1:0]   b_low;

    always_comb
    begin
        beat_next = beat_in;
        acc       = beat_in.acc;
        b_low     = gpmm_pkg::MUL_CHUNK'(beat_in.b);
        for (int j = 0; j < gpmm_pkg::MUL_CHUNK; j++) begin
            if (b_low[j]) begin
                acc = acc ^ (beat_in.a << j);
            end
        end
        beat_next.acc = acc;
        // a is pre-shifted left to keep the weight of the next chunk of b, which is shifted down to bit 0
        beat_next.a   = beat_in.a << gpmm_pkg::MUL_CHUNK;
        beat_next.b   = beat_in.b >> gpmm_pkg::MUL_CHUNK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            beat_reg.valid <= 1'b0;
        end else begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gpmm_reduce_stage.sv -----
// gpmm_reduce_stage: one register stage of the shift-and-xor remainder;
// shifts RED_STEPS product bits into the aligned remainder. Depends on gpmm_pkg.
`default_nettype none

module gpmm_reduce_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gpmm_pkg::mod_cfg_t  cfg,
    input  wire gpmm_pkg::red_beat_t beat_in,
    output gpmm_pkg::red_beat_t      beat_out
);

    gpmm_pkg::red_beat_t              beat_reg;
    gpmm_pkg::red_beat_t              beat_next;
    logic [gpmm_pkg::PAD_W-1:0]       p;
    gpmm_pkg::poly_t                  u;

    always_comb
    begin
        beat_next = beat_in;
        p         = beat_in.p;
        u         = beat_in.u;
        for (int k = 0; k < gpmm_pkg::RED_STEPS; k++) begin
            u = (u << 1) ^ (p[gpmm_pkg::PAD_W-1] ? cfg.sel : '0);
            if (u[gpmm_pkg::POLY_WIDTH-1]) begin
                u = u ^ cfg.mn;
            end
            p = p << 1;
        end
        beat_next.p = p;
        beat_next.u = u;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            beat_reg.valid <= 1'b0;
        end else begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gpmm_align.sv -----
// gpmm_align: output stage; right-aligns the remainder and forces zero on
// degree overflow. Depends on gpmm_pkg.
`default_nettype none

module gpmm_align (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gpmm_pkg::mod_cfg_t  cfg,
    input  wire gpmm_pkg::red_beat_t beat_in,
    output logic                     done,
    output gpmm_pkg::poly_t          product,
    output logic                     ovf
);

    logic                 done_reg;
    logic                 ovf_reg;
    gpmm_pkg::poly_t      product_reg;
    gpmm_pkg::poly_t      product_next;

    always_comb
    begin
        product_next = beat_in.ovf ? '0 : (beat_in.u >> cfg.shift);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg    <= beat_in.valid;
            ovf_reg     <= beat_in.ovf;
            product_reg <= product_next;
        end
    end

    assign done    = done_reg;
    assign product = product_reg;
    assign ovf     = ovf_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gpmm_modulus.sv -----
// gpmm_modulus: modulus register and the aligned modulus values derived from
// it through a registered degree and zero flag. Depends on gpmm_pkg.
`default_nettype none

module gpmm_modulus (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              we,
    input  wire gpmm_pkg::poly_t   wdata,
    output gpmm_pkg::mod_cfg_t     cfg
);

    gpmm_pkg::poly_t      modulus_reg;
    gpmm_pkg::deg_t       deg_reg;
    gpmm_pkg::deg_t       deg_next;
    logic                 zero_reg;
    logic                 zero_next;
    gpmm_pkg::mod_cfg_t   cfg_reg;
    gpmm_pkg::mod_cfg_t   cfg_next;
    gpmm_pkg::deg_t       shift;

    always_comb
    begin
        deg_next  = gpmm_pkg::poly_degree(modulus_reg);
        zero_next = (modulus_reg == '0);
        shift     = gpmm_pkg::deg_t'(gpmm_pkg::POLY_WIDTH - 1) - deg_reg;
        if (zero_reg) begin
            // no reduction: never xor, insert at bit 0 so the product passes through
            cfg_next.shift = '0;
            cfg_next.mn    = '0;
            cfg_next.sel   = gpmm_pkg::poly_t'(1);
        end else begin
            cfg_next.shift = shift;
            cfg_next.mn    = modulus_reg << shift;
            cfg_next.sel   = gpmm_pkg::poly_t'(1) << shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            modulus_reg   <= '0;
            deg_reg       <= '0;
            zero_reg      <= 1'b1;
            cfg_reg.shift <= '0;
            cfg_reg.mn    <= '0;
            cfg_reg.sel   <= gpmm_pkg::poly_t'(1);
        end else begin
            if (we) begin
                modulus_reg <= wdata;
            end
            deg_reg  <= deg_next;
            zero_reg <= zero_next;
            cfg_reg  <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gf2_poly_mul_mod.sv -----
// gf2_poly_mul_mod: top level of the pipelined GF(2) polynomial multiplier
// with programmable modulus. Depends on gpmm_pkg and the gpmm_* stage modules.
//
// Usage:
//   Input: drive operand_a/operand_b and pulse start; a beat is taken on
//   every clock edge where start is high and busy is low. busy is always low:
//   a new operand pair may enter every cycle.
//   Output: done is high for one cycle with product_poly and degree_overflow.
//   Results come out in input order, through 1 degree-check stage, 4 multiply
//   stages, 8 reduction stages and 1 output stage. Throughput is one result
//   per cycle, set by the fully pipelined multiply and reduction stages.
//   Config: modulus_we writes modulus_poly; zero disables reduction. Write it
//   only while no beat is in flight; derived values settle via the degree and
//   zero-flag registers before the first new beat reaches reduction.
//   Reset: all stage valid bits clear, modulus returns to zero.
//   The receiver cannot stall; done is a strobe and results are not held.
`default_nettype none

module gf2_poly_mul_mod (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire gpmm_pkg::poly_t   operand_a,
    input  wire gpmm_pkg::poly_t   operand_b,
    input  wire logic              modulus_we,
    input  wire gpmm_pkg::poly_t   modulus_poly,
    output logic                   done,
    output gpmm_pkg::poly_t        product_poly,
    output logic                   degree_overflow
);

    gpmm_pkg::mul_beat_t   mul_pipe [gpmm_pkg::MUL_STAGES+1];
    gpmm_pkg::red_beat_t   red_pipe [gpmm_pkg::RED_STAGES+1];
    gpmm_pkg::mod_cfg_t    cfg;
    logic                  accept;

    // fully pipelined, never back-pressures
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    gpmm_modulus u_modulus (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (modulus_we),
        .wdata (modulus_poly),
        .cfg   (cfg)
    );

    gpmm_degree u_degree (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .a        (operand_a),
        .b        (operand_b),
        .beat_out (mul_pipe[0])
    );

    for (genvar gi = 0; gi < gpmm_pkg::MUL_STAGES; gi++) begin : g_mul
        gpmm_clmul_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .beat_in  (mul_pipe[gi]),
            .beat_out (mul_pipe[gi+1])
        );
    end

    always_comb
    begin
        red_pipe[0].valid = mul_pipe[gpmm_pkg::MUL_STAGES].valid;
        red_pipe[0].ovf   = mul_pipe[gpmm_pkg::MUL_STAGES].ovf;
        // any zero padding on top feeds leading zeros, which leave the remainder at zero
        red_pipe[0].p     = gpmm_pkg::PAD_W'(mul_pipe[gpmm_pkg::MUL_STAGES].acc);
        red_pipe[0].u     = '0;
    end

    for (genvar gr = 0; gr < gpmm_pkg::RED_STAGES; gr++) begin : g_red
        gpmm_reduce_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg      (cfg),
            .beat_in  (red_pipe[gr]),
            .beat_out (red_pipe[gr+1])
        );
    end

    gpmm_align u_align (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .beat_in (red_pipe[gpmm_pkg::RED_STAGES]),
        .done    (done),
        .product (product_poly),
        .ovf     (degree_overflow)
    );

endmodule

`default_nettype wire
